FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master register-access block.
// No dependencies; used by i2cm_front, i2cm_back and the top level.
package i2cm_pkg;

  // Bytes read in one burst, and the index of the final one.
  localparam int          BURST_BYTES = 14;
  localparam logic [5:0]  LAST_INDEX  = 6'(BURST_BYTES - 1);

  // Configuration register indexes (byte address 4*index).
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BURST_START    = 2'd1;
  localparam logic [1:0] REG_TICKS_DELAY    = 2'd2;

  // Input command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_RSVD  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd104;
  localparam logic [7:0] BURST_START_RST    = 8'd59;
  localparam logic [9:0] TICKS_DELAY_RST    = 10'd48;

  // Transaction kind, also the decoded command class.
  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  // Bus sequencer phase.
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START  = 3'd1,
    PH_TX_LO  = 3'd2,
    PH_TX_HI  = 3'd3,
    PH_RSTART = 3'd4,
    PH_RX_LO  = 3'd5,
    PH_RX_HI  = 3'd6,
    PH_STOP   = 3'd7
  } phase_t;

  // One input beat as it arrives on the port.
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       read_valid;
    logic [7:0] read_byte;
    logic [5:0] byte_index;
    logic       last;
    logic       nack;
  } out_item_t;

  // A classified tick as it waits in the queue.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  // Configuration values seen by the sequencer.
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] burst_start_register;
    logic [9:0] ticks_per_delay;
  } cfg_t;

endpackage

FILE: sv/i2cm_front.sv
// Front end: accepts input beats, classifies the command and holds them in a
// two-entry queue for the sequencer. Depends on i2cm_pkg.
module i2cm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cm_pkg::in_item_t in_data,
  output logic              q_valid,
  output i2cm_pkg::tick_t   q_item,
  input  logic              q_pop
);

  i2cm_pkg::tick_t q_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;
  logic            push;
  i2cm_pkg::tick_t dec;

  // Classify: codes outside write/read are plain ticks.
  always_comb begin
    dec.target_reg = in_data.target_reg;
    dec.write_data = in_data.write_data;
    dec.sda_in     = in_data.sda_in;
    unique case (in_data.command)
      i2cm_pkg::CMD_WRITE: dec.kind = i2cm_pkg::KIND_WRITE;
      i2cm_pkg::CMD_READ:  dec.kind = i2cm_pkg::KIND_READ;
      default:             dec.kind = i2cm_pkg::KIND_NONE;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 2'd2)
    else $error("queue count out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> count_r != 2'd0)
    else $error("pop from empty queue");

endmodule

FILE: sv/i2cm_back.sv
// Back end: the bus sequencer, one tick per queued beat, with the result
// output register. Depends on i2cm_pkg.
module i2cm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  i2cm_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  i2cm_pkg::tick_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output i2cm_pkg::out_item_t out_data
);

  i2cm_pkg::phase_t    phase_r, phase_nxt, ph_e;
  i2cm_pkg::kind_t     kind_r, kind_nxt, kind_e;
  logic [3:0]          bit_r, bit_nxt, bit_e;
  logic [5:0]          byte_r, byte_nxt, byte_e;
  logic [9:0]          dly_r, dly_nxt, dly_e;
  logic [7:0]          shift_r, shift_nxt, shift_e;
  logic [7:0]          pend_r, pend_nxt, pend_e;
  logic                nack_r, nack_nxt;
  logic                out_valid_r;
  i2cm_pkg::out_item_t out_data_r, res;
  logic [7:0]          addr_byte, tx_byte;
  logic [9:0]          limit;
  logic                seg_end, is_last, scl, sda;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    // Take a command only while idle; it is also the first start tick.
    ph_e    = phase_r;
    kind_e  = kind_r;
    bit_e   = bit_r;
    byte_e  = byte_r;
    dly_e   = dly_r;
    shift_e = shift_r;
    pend_e  = pend_r;
    if (phase_r == i2cm_pkg::PH_IDLE && q_item.kind != i2cm_pkg::KIND_NONE) begin
      ph_e    = i2cm_pkg::PH_START;
      kind_e  = q_item.kind;
      bit_e   = 4'd0;
      byte_e  = 6'd0;
      dly_e   = 10'd0;
      shift_e = (q_item.kind == i2cm_pkg::KIND_WRITE) ? q_item.target_reg : 8'd0;
      pend_e  = q_item.write_data;
    end

    addr_byte = {cfg.device_address, 1'b0};
    if (byte_e == 6'd0) begin
      tx_byte = addr_byte;
    end else if (byte_e == 6'd1) begin
      tx_byte = (kind_e == i2cm_pkg::KIND_WRITE) ? shift_e : cfg.burst_start_register;
    end else begin
      tx_byte = (kind_e == i2cm_pkg::KIND_WRITE) ? pend_e : (addr_byte | 8'd1);
    end
    is_last = (byte_e == i2cm_pkg::LAST_INDEX);

    // Line drives for this tick.
    scl = 1'b1;
    sda = 1'b1;
    unique case (ph_e)
      i2cm_pkg::PH_IDLE: begin
      end
      i2cm_pkg::PH_START: begin
        scl = (bit_e < 4'd2);
        sda = (bit_e == 4'd0);
      end
      i2cm_pkg::PH_TX_LO, i2cm_pkg::PH_TX_HI: begin
        scl = (ph_e == i2cm_pkg::PH_TX_HI);
        sda = (bit_e < 4'd8) ? tx_byte[~bit_e[2:0]] : 1'b1;
      end
      i2cm_pkg::PH_RSTART: begin
        scl = (bit_e == 4'd1) || (bit_e == 4'd2);
        sda = (bit_e < 4'd2);
      end
      i2cm_pkg::PH_RX_LO, i2cm_pkg::PH_RX_HI: begin
        scl = (ph_e == i2cm_pkg::PH_RX_HI);
        sda = (bit_e < 4'd8) ? 1'b1 : is_last;
      end
      i2cm_pkg::PH_STOP: begin
        scl = (bit_e != 4'd0);
        sda = (bit_e == 4'd2);
      end
      default: begin
      end
    endcase

    phase_nxt = ph_e;
    kind_nxt  = kind_e;
    bit_nxt   = bit_e;
    byte_nxt  = byte_e;
    dly_nxt   = dly_e;
    shift_nxt = shift_e;
    pend_nxt  = pend_e;
    nack_nxt  = nack_r;
    res.read_valid = 1'b0;
    res.read_byte  = 8'd0;
    res.byte_index = 6'd0;
    res.last       = 1'b0;

    limit   = (cfg.ticks_per_delay == 10'd0) ? 10'd1 : cfg.ticks_per_delay;
    seg_end = ({1'b0, dly_e} + 11'd1) >= {1'b0, limit};

    if (ph_e != i2cm_pkg::PH_IDLE) begin
      dly_nxt = seg_end ? 10'd0 : (dly_e + 10'd1);
      if (seg_end) begin
        unique case (ph_e)
          i2cm_pkg::PH_START: begin
            if (bit_e >= 4'd2) begin
              phase_nxt = i2cm_pkg::PH_TX_LO;
              bit_nxt   = 4'd0;
              byte_nxt  = 6'd0;
            end else begin
              bit_nxt = bit_e + 4'd1;
            end
          end
          i2cm_pkg::PH_TX_LO: phase_nxt = i2cm_pkg::PH_TX_HI;
          i2cm_pkg::PH_TX_HI: begin
            if (bit_e < 4'd8) begin
              bit_nxt   = bit_e + 4'd1;
              phase_nxt = i2cm_pkg::PH_TX_LO;
            end else begin
              nack_nxt = q_item.sda_in;
              bit_nxt  = 4'd0;
              if (kind_e == i2cm_pkg::KIND_WRITE) begin
                if (byte_e >= 6'd2) begin
                  phase_nxt = i2cm_pkg::PH_STOP;
                end else begin
                  byte_nxt  = byte_e + 6'd1;
                  phase_nxt = i2cm_pkg::PH_TX_LO;
                end
              end else if (byte_e == 6'd0) begin
                byte_nxt  = 6'd1;
                phase_nxt = i2cm_pkg::PH_TX_LO;
              end else if (byte_e == 6'd1) begin
                phase_nxt = i2cm_pkg::PH_RSTART;
              end else begin
                byte_nxt  = 6'd0;
                shift_nxt = 8'd0;
                phase_nxt = i2cm_pkg::PH_RX_LO;
              end
            end
          end
          i2cm_pkg::PH_RSTART: begin
            if (bit_e >= 4'd3) begin
              phase_nxt = i2cm_pkg::PH_TX_LO;
              bit_nxt   = 4'd0;
              byte_nxt  = 6'd2;
            end else begin
              bit_nxt = bit_e + 4'd1;
            end
          end
          i2cm_pkg::PH_RX_LO: phase_nxt = i2cm_pkg::PH_RX_HI;
          i2cm_pkg::PH_RX_HI: begin
            if (bit_e < 4'd8) begin
              shift_nxt = {shift_e[6:0], q_item.sda_in};
              if (bit_e == 4'd7) begin
                res.read_valid = 1'b1;
                res.read_byte  = {shift_e[6:0], q_item.sda_in};
                res.byte_index = byte_e;
                res.last       = is_last;
              end
              bit_nxt   = bit_e + 4'd1;
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end else if (is_last || byte_e >= 6'd63) begin
              bit_nxt   = 4'd0;
              phase_nxt = i2cm_pkg::PH_STOP;
            end else begin
              byte_nxt  = byte_e + 6'd1;
              bit_nxt   = 4'd0;
              shift_nxt = 8'd0;
              phase_nxt = i2cm_pkg::PH_RX_LO;
            end
          end
          i2cm_pkg::PH_STOP: begin
            if (bit_e >= 4'd2) begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              bit_nxt   = 4'd0;
              kind_nxt  = i2cm_pkg::KIND_NONE;
            end else begin
              bit_nxt = bit_e + 4'd1;
            end
          end
          default: phase_nxt = i2cm_pkg::PH_IDLE;
        endcase
      end
    end

    res.scl_out  = scl;
    res.sda_out  = sda;
    res.busy_res = (phase_nxt != i2cm_pkg::PH_IDLE) || !scl || !sda;
    res.nack     = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= i2cm_pkg::PH_IDLE;
      kind_r      <= i2cm_pkg::KIND_NONE;
      bit_r       <= 4'd0;
      byte_r      <= 6'd0;
      dly_r       <= 10'd0;
      shift_r     <= 8'd0;
      pend_r      <= 8'd0;
      nack_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r <= phase_nxt;
        kind_r  <= kind_nxt;
        bit_r   <= bit_nxt;
        byte_r  <= byte_nxt;
        dly_r   <= dly_nxt;
        shift_r <= shift_nxt;
        pend_r  <= pend_nxt;
        nack_r  <= nack_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res;
    end
  end

  a_sample_scl_high: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && res.read_valid |-> res.scl_out)
    else $error("byte delivered outside a high SCL segment");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == i2cm_pkg::PH_IDLE |-> bit_r == 4'd0 && kind_r == i2cm_pkg::KIND_NONE)
    else $error("idle with stale bit count or kind");

  a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_r <= 4'd8)
    else $error("bit count out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !q_pop)
    else $error("sequencer advanced while result was stalled");

endmodule

FILE: sv/i2c_master_register_access.sv
// Top level of the I2C master register-access block: configuration
// registers, APB-style port, front queue and bus sequencer.
// Depends on i2cm_pkg, i2cm_front and i2cm_back.
//
// Usage:
//   Each input beat is one bus tick: command (0 tick, 1 register write,
//   2 burst read), the write register and data, and the sampled SDA level.
//   Each accepted beat yields exactly one result beat with the SCL/SDA
//   drives, busy, nack and, at the end of the eighth read bit, a received
//   byte with its burst index and last mark.
//   Throughput is one beat per cycle while the result is not stalled; the
//   sequencer retires one tick per clock. Each beat passes through the
//   front queue and then the output register.
//   Commands that arrive while a transaction runs are treated as plain
//   ticks. One bus segment lasts ticks_per_delay beats.
//   When out_stall is high over a valid result, that result holds, the
//   sequencer freezes, and the two-entry queue takes input until full, then in_stall rises.
//   Reset (synchronous, rst_n low) empties the queue, drops any pending
//   result, returns the sequencer to idle and loads the register defaults:
//   device address 104, burst start register 59, 48 ticks per delay.
//   Write registers only while the block is idle.
module i2c_master_register_access (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [6:0]      dev_addr_r;
  logic [7:0]      burst_start_r;
  logic [9:0]      ticks_r;
  logic            cfg_wr;
  logic [1:0]      cfg_sel;
  i2cm_pkg::cfg_t  cfg;
  logic            q_valid;
  logic            q_pop;
  i2cm_pkg::tick_t q_item;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  // Register file: write on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r    <= i2cm_pkg::DEVICE_ADDRESS_RST;
      burst_start_r <= i2cm_pkg::BURST_START_RST;
      ticks_r       <= i2cm_pkg::TICKS_DELAY_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        i2cm_pkg::REG_DEVICE_ADDRESS: dev_addr_r    <= pwdata[6:0];
        i2cm_pkg::REG_BURST_START:    burst_start_r <= pwdata[7:0];
        i2cm_pkg::REG_TICKS_DELAY:    ticks_r       <= pwdata[9:0];
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (cfg_sel)
      i2cm_pkg::REG_DEVICE_ADDRESS: prdata = {25'd0, dev_addr_r};
      i2cm_pkg::REG_BURST_START:    prdata = {24'd0, burst_start_r};
      i2cm_pkg::REG_TICKS_DELAY:    prdata = {22'd0, ticks_r};
      default:                      prdata = 32'd0;
    endcase
  end

  assign cfg.device_address       = dev_addr_r;
  assign cfg.burst_start_register = burst_start_r;
  assign cfg.ticks_per_delay      = ticks_r;

  i2cm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: test/tb_i2c_master_register_access.sv
// Self-checking testbench for i2c_master_register_access: tick-by-tick bus predictor,
// APB register writes between phases, random idling on both channels.
// Depends on i2cm_pkg and the i2c_master_register_access RTL.
module tb_i2c_master_register_access;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;

  // Line drives seen while the bus is idle, and on the tick that accepts a command.
  localparam i2cm_pkg::out_item_t IDLE_LINES =
    '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 6'h00, 1'b0, 1'b0};
  localparam i2cm_pkg::out_item_t START_TICK =
    '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 6'h00, 1'b0, 1'b0};
  localparam i2cm_pkg::out_item_t NOT_TYPED  =
    '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 6'h00, 1'b0, 1'b0};

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    i2cm_pkg::in_item_t  beat;
    bit                  typed;
    i2cm_pkg::out_item_t want;
  } dir_row_t;

  typedef struct {
    logic [6:0] dev;
    logic [7:0] burst;
    logic [9:0] ticks;
    idle_mode_t mode;
    int         items;
    bit         shuffle;
    bit         long_hold;
    bit         mid_pause;
  } run_phase_t;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  i2cm_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  i2cm_pkg::out_item_t out_data;
  logic                psel      = 1'b0;
  logic                penable   = 1'b0;
  logic                pwrite    = 1'b0;
  logic [3:0]          paddr     = '0;
  logic [31:0]         pwdata    = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Predicted sequencer state and register copies.
  i2cm_pkg::phase_t seq_phase;
  i2cm_pkg::kind_t  seq_kind;
  logic [3:0]       bit_cnt;
  logic [7:0]       shift_reg;
  logic [5:0]       byte_cnt;
  logic [9:0]       delay_cnt;
  logic [7:0]       held_data;
  logic             nack_seen;
  logic [6:0]       dev_addr;
  logic [7:0]       burst_reg;
  logic [9:0]       seg_ticks;

  i2cm_pkg::out_item_t tick_results_q[$];
  int          fail_count = 0;
  int          beats_seen = 0;
  int          gap_pct    = 0;
  int          stall_pct  = 0;
  logic        hold_go    = 1'b0;
  bit          hold_taken = 1'b0;
  int          hold_left  = 0;
  int unsigned cycles     = 0;

  i2c_master_register_access dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the bus sequencer by one tick and return the line drives it produces.
  function automatic i2cm_pkg::out_item_t advance_sequencer(input i2cm_pkg::in_item_t beat);
    i2cm_pkg::out_item_t r;
    logic [9:0]          lim;
    logic [7:0]          txb;
    logic                seg_end;
    r = NOT_TYPED;
    r.scl_out = 1'b1;
    r.sda_out = 1'b1;
    lim = (seg_ticks == 10'd0) ? 10'd1 : seg_ticks;

    // The accepting tick is already the first tick of the start condition.
    if (seq_phase == i2cm_pkg::PH_IDLE &&
        (beat.command == i2cm_pkg::CMD_WRITE || beat.command == i2cm_pkg::CMD_READ)) begin
      seq_phase = i2cm_pkg::PH_START;
      seq_kind  = i2cm_pkg::kind_t'(beat.command);
      bit_cnt   = '0;
      byte_cnt  = '0;
      delay_cnt = '0;
      shift_reg = (beat.command == i2cm_pkg::CMD_WRITE) ? beat.target_reg : 8'h00;
      held_data = beat.write_data;
    end

    case (seq_phase)
      i2cm_pkg::PH_START: begin
        r.scl_out = bit_cnt < 4'd2;
        r.sda_out = bit_cnt == 4'd0;
      end
      i2cm_pkg::PH_TX_LO, i2cm_pkg::PH_TX_HI: begin
        // Address and start register are taken live from the registers.
        txb = {dev_addr, 1'b0};
        if (byte_cnt == 6'd1)
          txb = (seq_kind == i2cm_pkg::KIND_WRITE) ? shift_reg : burst_reg;
        else if (byte_cnt > 6'd1)
          txb = (seq_kind == i2cm_pkg::KIND_WRITE) ? held_data : {dev_addr, 1'b1};
        r.scl_out = seq_phase == i2cm_pkg::PH_TX_HI;
        r.sda_out = (bit_cnt < 4'd8) ? txb[3'd7 - bit_cnt[2:0]] : 1'b1;
      end
      i2cm_pkg::PH_RSTART: begin
        r.scl_out = bit_cnt == 4'd1 || bit_cnt == 4'd2;
        r.sda_out = bit_cnt < 4'd2;
      end
      i2cm_pkg::PH_RX_LO, i2cm_pkg::PH_RX_HI: begin
        // Master ACKs every byte but the last one.
        r.scl_out = seq_phase == i2cm_pkg::PH_RX_HI;
        r.sda_out = (bit_cnt < 4'd8) ? 1'b1 : (byte_cnt == i2cm_pkg::LAST_INDEX);
      end
      i2cm_pkg::PH_STOP: begin
        r.scl_out = bit_cnt != 4'd0;
        r.sda_out = bit_cnt == 4'd2;
      end
      default: ;
    endcase

    if (seq_phase != i2cm_pkg::PH_IDLE) begin
      // A lowered segment length ends the running segment at once.
      seg_end   = ({1'b0, delay_cnt} + 11'd1) >= {1'b0, lim};
      delay_cnt = seg_end ? 10'd0 : delay_cnt + 10'd1;
      if (seg_end) begin
        case (seq_phase)
          i2cm_pkg::PH_START: begin
            if (bit_cnt >= 4'd2) begin
              seq_phase = i2cm_pkg::PH_TX_LO;
              bit_cnt   = '0;
              byte_cnt  = '0;
            end else bit_cnt++;
          end
          i2cm_pkg::PH_TX_LO: seq_phase = i2cm_pkg::PH_TX_HI;
          i2cm_pkg::PH_TX_HI: begin
            if (bit_cnt < 4'd8) begin
              bit_cnt++;
              seq_phase = i2cm_pkg::PH_TX_LO;
            end else begin
              // Slave ACK slot: record the level, carry on regardless.
              nack_seen = beat.sda_in;
              bit_cnt   = '0;
              if (seq_kind == i2cm_pkg::KIND_WRITE) begin
                if (byte_cnt >= 6'd2) seq_phase = i2cm_pkg::PH_STOP;
                else begin
                  byte_cnt++;
                  seq_phase = i2cm_pkg::PH_TX_LO;
                end
              end else if (byte_cnt == 6'd0) begin
                byte_cnt  = 6'd1;
                seq_phase = i2cm_pkg::PH_TX_LO;
              end else if (byte_cnt == 6'd1) begin
                seq_phase = i2cm_pkg::PH_RSTART;
              end else begin
                byte_cnt  = '0;
                shift_reg = '0;
                seq_phase = i2cm_pkg::PH_RX_LO;
              end
            end
          end
          i2cm_pkg::PH_RSTART: begin
            if (bit_cnt >= 4'd3) begin
              seq_phase = i2cm_pkg::PH_TX_LO;
              bit_cnt   = '0;
              byte_cnt  = 6'd2;
            end else bit_cnt++;
          end
          i2cm_pkg::PH_RX_LO: seq_phase = i2cm_pkg::PH_RX_HI;
          i2cm_pkg::PH_RX_HI: begin
            if (bit_cnt < 4'd8) begin
              shift_reg = {shift_reg[6:0], beat.sda_in};
              if (bit_cnt == 4'd7) begin
                r.read_valid = 1'b1;
                r.read_byte  = shift_reg;
                r.byte_index = byte_cnt;
                r.last       = byte_cnt == i2cm_pkg::LAST_INDEX;
              end
              bit_cnt++;
              seq_phase = i2cm_pkg::PH_RX_LO;
            end else if (byte_cnt == i2cm_pkg::LAST_INDEX || byte_cnt >= 6'd63) begin
              bit_cnt   = '0;
              seq_phase = i2cm_pkg::PH_STOP;
            end else begin
              byte_cnt++;
              bit_cnt   = '0;
              shift_reg = '0;
              seq_phase = i2cm_pkg::PH_RX_LO;
            end
          end
          i2cm_pkg::PH_STOP: begin
            if (bit_cnt >= 4'd2) begin
              seq_phase = i2cm_pkg::PH_IDLE;
              bit_cnt   = '0;
              seq_kind  = i2cm_pkg::KIND_NONE;
            end else bit_cnt++;
          end
          default: seq_phase = i2cm_pkg::PH_IDLE;
        endcase
      end
    end

    r.busy_res = (seq_phase != i2cm_pkg::PH_IDLE) || !r.scl_out || !r.sda_out;
    r.nack     = nack_seen;
    return r;
  endfunction

  // Offer one beat, hold it until accepted, then queue its expected result.
  task automatic send_beat(input i2cm_pkg::in_item_t beat, input bit typed,
                           input i2cm_pkg::out_item_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (typed) begin
      void'(advance_sequencer(beat));
      tick_results_q.push_back(want);
    end else begin
      tick_results_q.push_back(advance_sequencer(beat));
    end
  endtask

  // Drop valid and wait until every expected result is back, plus the pipeline depth.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (tick_results_q.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, access cycle, then release the bus.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      i2cm_pkg::REG_DEVICE_ADDRESS: dev_addr  = val[6:0];
      i2cm_pkg::REG_BURST_START:    burst_reg = val[7:0];
      i2cm_pkg::REG_TICKS_DELAY:    seg_ticks = val[9:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= 10)
        $display("mismatch on result beat %0d, %s: expected %0h, got %0h",
                 beats_seen, name, want, got);
    end
  endtask

  // Result side: compare each beat with the oldest expectation, then pick the next stall.
  initial begin : result_monitor
    i2cm_pkg::out_item_t want;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
        beats_seen++;
        if (tick_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("result beat %0d arrived with none expected", beats_seen);
        end else begin
          want = tick_results_q.pop_front();
          check_field("scl_out",    8'(want.scl_out),    8'(out_data.scl_out));
          check_field("sda_out",    8'(want.sda_out),    8'(out_data.sda_out));
          check_field("busy_res",   8'(want.busy_res),   8'(out_data.busy_res));
          check_field("read_valid", 8'(want.read_valid), 8'(out_data.read_valid));
          check_field("read_byte",  want.read_byte,      out_data.read_byte);
          check_field("byte_index", 8'(want.byte_index), 8'(out_data.byte_index));
          check_field("last",       8'(want.last),       8'(out_data.last));
          check_field("nack",       8'(want.nack),       8'(out_data.nack));
        end
      end
      // One long hold-off so the queue fills and the input side stalls.
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: report failure and end the run at the cycle limit, whatever the progress.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // Directed beats at the reset register values (48 ticks per segment).
  dir_row_t dir_rows [14] = '{
    // idle ticks with all-zero and all-one payloads
    '{'{i2cm_pkg::CMD_TICK,  8'h00, 8'h00, 1'b0}, 1'b1, IDLE_LINES},
    '{'{i2cm_pkg::CMD_TICK,  8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_LINES},
    // reserved command does nothing
    '{'{i2cm_pkg::CMD_RSVD,  8'hFF, 8'hFF, 1'b1}, 1'b1, IDLE_LINES},
    '{'{i2cm_pkg::CMD_RSVD,  8'h00, 8'h00, 1'b0}, 1'b1, IDLE_LINES},
    // accepting tick is the first start tick
    '{'{i2cm_pkg::CMD_WRITE, 8'hFF, 8'h00, 1'b0}, 1'b1, START_TICK},
    // commands while busy are plain ticks
    '{'{i2cm_pkg::CMD_READ,  8'h00, 8'hFF, 1'b1}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_WRITE, 8'h00, 8'hFF, 1'b0}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_RSVD,  8'hAA, 8'h55, 1'b1}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_TICK,  8'h55, 8'hAA, 1'b0}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_TICK,  8'h00, 8'h00, 1'b1}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_READ,  8'hFF, 8'hFF, 1'b0}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_TICK,  8'h0F, 8'hF0, 1'b1}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_TICK,  8'hF0, 8'h0F, 1'b0}, 1'b0, NOT_TYPED},
    '{'{i2cm_pkg::CMD_TICK,  8'h80, 8'h01, 1'b1}, 1'b0, NOT_TYPED}
  };

  // Random phases: register extremes first, then mixed settings. The first
  // phase's writes land in the middle of the directed transaction, so the new
  // segment length (zero, acting as one) cuts the running segment short.
  run_phase_t run_phases [7] = '{
    '{7'h7F, 8'h00, 10'd0,    IDLE_NONE,     300, 1'b0, 1'b0, 1'b0},
    '{7'h00, 8'hFF, 10'd1,    IDLE_SENDER,   300, 1'b0, 1'b0, 1'b0},
    '{7'h00, 8'h00, 10'd2,    IDLE_RECEIVER, 300, 1'b1, 1'b1, 1'b0},
    '{7'h00, 8'h00, 10'd1,    IDLE_BOTH,     300, 1'b1, 1'b0, 1'b1},
    '{7'h00, 8'h00, 10'd3,    IDLE_NONE,     250, 1'b1, 1'b0, 1'b0},
    '{7'h00, 8'h00, 10'd1023, IDLE_BOTH,     40,  1'b1, 1'b0, 1'b0},
    '{7'h00, 8'h00, 10'd1,    IDLE_NONE,     400, 1'b1, 1'b0, 1'b0}
  };

  initial begin : stimulus
    i2cm_pkg::in_item_t beat;
    run_phase_t         ph;
    logic [6:0]         dev;
    logic [7:0]         burst;

    // Predictor starts from the reset state and register defaults.
    seq_phase = i2cm_pkg::PH_IDLE;
    seq_kind  = i2cm_pkg::KIND_NONE;
    bit_cnt   = '0;
    shift_reg = '0;
    byte_cnt  = '0;
    delay_cnt = '0;
    held_data = '0;
    nack_seen = 1'b0;
    dev_addr  = i2cm_pkg::DEVICE_ADDRESS_RST;
    burst_reg = i2cm_pkg::BURST_START_RST;
    seg_ticks = i2cm_pkg::TICKS_DELAY_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
    drain();

    foreach (run_phases[p]) begin
      ph    = run_phases[p];
      dev   = ph.shuffle ? 7'($urandom) : ph.dev;
      burst = ph.shuffle ? 8'($urandom) : ph.burst;
      write_reg(i2cm_pkg::REG_DEVICE_ADDRESS, 32'(dev));
      write_reg(i2cm_pkg::REG_BURST_START, 32'(burst));
      write_reg(i2cm_pkg::REG_TICKS_DELAY, 32'(ph.ticks));
      case (ph.mode)
        IDLE_NONE:     begin gap_pct = 0;  stall_pct = 0;  end
        IDLE_SENDER:   begin gap_pct = 48; stall_pct = 0;  end
        IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 48; end
        default:       begin gap_pct = 10; stall_pct = 10; end
      endcase

      for (int n = 0; n < ph.items; n++) begin
        if (ph.long_hold && n == 50) hold_go <= 1'b1;
        // Pause the sender until every outstanding result is back.
        if (ph.mid_pause && n == ph.items / 2) drain();
        beat.target_reg = 8'($urandom);
        beat.write_data = 8'($urandom);
        beat.sda_in     = 1'($urandom);
        // Mostly start a transaction as soon as the bus goes idle; otherwise tick,
        // with some noise commands that the busy sequencer must ignore.
        if (seq_phase == i2cm_pkg::PH_IDLE && $urandom_range(3) != 0)
          beat.command = ($urandom_range(1) != 0) ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE;
        else if ($urandom_range(9) == 0)
          beat.command = 2'($urandom_range(3));
        else
          beat.command = i2cm_pkg::CMD_TICK;
        send_beat(beat, 1'b0, NOT_TYPED);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
